[hdl/tprma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tprma_pkg
// Shared constants for the tach period to rpm converter and its divider.
// ----------------------------------------------------------------------------
package tprma_pkg;

  // field widths
  localparam int CapW    = 16;
  localparam int OvfW    = 16;
  localparam int PeriodW = 32;
  localparam int RpmW    = 28;
  localparam int TickW   = 28;
  localparam int PprW    = 8;
  localparam int OpW     = 2;
  localparam int CfgIdxW = 2;

  // divider operand widths: tick_rate * 60 and period * pulses_per_rev
  localparam int NumW = TickW + 6;
  localparam int DenW = PeriodW + PprW;

  // rpm ceiling
  localparam logic [RpmW-1:0] RpmMax = RpmW'(170000000);

  // configuration register reset values
  localparam logic [TickW-1:0] TickRateReset = TickW'(28333333);
  localparam logic [PprW-1:0]  PprReset      = PprW'(60);

  // op codes
  localparam logic [OpW-1:0] OpCapture   = 2'd0;
  localparam logic [OpW-1:0] OpOverflow  = 2'd1;
  localparam logic [OpW-1:0] OpFilterClr = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTickRate     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPulsesPerRev = 2'd1;

endpackage
`default_nettype wire

[hdl/tprma_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tprma_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tprma_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [tprma_pkg::NumW-1:0] num_i,
  input  wire logic [tprma_pkg::DenW-1:0] den_i,
  output logic                          busy_o,
  output logic [tprma_pkg::NumW-1:0]    quot_o
);
  import tprma_pkg::*;

  localparam int CntW = $clog2(NumW);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [NumW-1:0] sh_q, sh_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW+1:0] trial;
  logic            ge;

  // trial subtract of the divisor from the shifted partial remainder
  assign trial = {1'b0, rem_q, sh_q[NumW-1]} - {2'b00, den_q};
  assign ge    = ~trial[DenW+1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW - 1);
      rem_d  = '0;
      sh_d   = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? trial[DenW-1:0] : {rem_q[DenW-2:0], sh_q[NumW-1]};
      sh_d  = {sh_q[NumW-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = sh_q;

endmodule
`default_nettype wire

[hdl/tach_period_rpm_moving_average_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tach_period_rpm_moving_average_top
// Tach capture period measurement, rpm conversion and moving average filter.
// ----------------------------------------------------------------------------
// Overflow, filter clear and first capture beats complete in the idle state.
// A later capture steps through StMul, StDiv1 and StDiv2 on the shared
// bit-serial divider (rpm quotient, then average quotient); the input
// stalls until the result is loaded, which waits while the prior result stalls.
// Reset clears capture state, overflow count, ring, sum and fill count and
// loads the configuration reset values; no clearing pass is needed.
module tach_period_rpm_moving_average_top #(
  parameter int WINDOW     = 6,
  parameter int TIMER_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tprma_pkg::OpW-1:0]     op_i,
  input  wire logic [tprma_pkg::CapW-1:0]    capture_value_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tprma_pkg::PeriodW-1:0]      period_ticks_o,
  output logic [tprma_pkg::RpmW-1:0]         raw_rpm_o,
  output logic [tprma_pkg::RpmW-1:0]         avg_rpm_o,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tprma_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [tprma_pkg::TickW-1:0]   cfg_data_i
);
  import tprma_pkg::*;

  localparam int IdxW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FillW = $clog2(WINDOW + 1);
  localparam int SumW  = RpmW + $clog2(WINDOW);
  localparam logic [CapW-1:0] CapMask =
    (TIMER_BITS >= CapW) ? {CapW{1'b1}} : CapW'((1 << TIMER_BITS) - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv1 = 2'd2;
  localparam logic [1:0] StDiv2 = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [TickW-1:0]   tick_q;
  logic [PprW-1:0]    ppr_q;
  logic [CapW-1:0]    last_q, last_d;
  logic               seen_q, seen_d;
  logic [OvfW-1:0]    ovf_q, ovf_d;
  logic [RpmW-1:0]    ring_q [WINDOW];
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic               den_zero_q, den_zero_d;
  logic [RpmW-1:0]    rpm_q, rpm_d;
  logic               ring_wr, ring_clr;

  logic               out_valid_q, out_valid_d;
  logic [PeriodW-1:0] out_period_q;
  logic [RpmW-1:0]    out_raw_q, out_filt_q;
  logic               out_load;

  logic               in_beat;
  logic [CapW-1:0]    cap_m;
  logic [PeriodW-1:0] period_calc;
  logic [NumW-1:0]    rpm_num;
  logic [DenW-1:0]    rpm_den;
  logic [RpmW-1:0]    rpm_w;

  logic               div_start, div_busy;
  logic [NumW-1:0]    div_num, div_quot;
  logic [DenW-1:0]    div_den;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign in_beat     = in_valid_i & ~in_stall_o;

  // period from overflow count and capture difference, modulo 2^32
  assign cap_m       = capture_value_i & CapMask;
  assign period_calc = ({{(PeriodW-OvfW){1'b0}}, ovf_q} << TIMER_BITS)
                     + ({{(PeriodW-CapW){1'b0}}, cap_m}
                        - {{(PeriodW-CapW){1'b0}}, last_q});

  // rpm numerator tick_rate * 60 and denominator period * pulses_per_rev
  assign rpm_num = {tick_q, 6'b0} - {4'b0, tick_q, 2'b0};
  assign rpm_den = {{(DenW-PeriodW){1'b0}}, period_q} * {{(DenW-PprW){1'b0}}, ppr_q};

  // saturated rpm from the first quotient
  always_comb begin
    if (den_zero_q) begin
      rpm_w = '0;
    end else if (div_quot > NumW'(RpmMax)) begin
      rpm_w = RpmMax;
    end else begin
      rpm_w = div_quot[RpmW-1:0];
    end
  end

  // sequencer and filter state update
  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    seen_d     = seen_q;
    ovf_d      = ovf_q;
    idx_d      = idx_q;
    fill_d     = fill_q;
    sum_d      = sum_q;
    period_d   = period_q;
    den_zero_d = den_zero_q;
    rpm_d      = rpm_q;
    ring_wr    = 1'b0;
    ring_clr   = 1'b0;
    div_start  = 1'b0;
    div_num    = rpm_num;
    div_den    = rpm_den;
    out_load   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          priority if (op_i == OpOverflow) begin
            if (ovf_q != {OvfW{1'b1}}) ovf_d = ovf_q + 1'b1;
          end else if (op_i == OpFilterClr) begin
            ring_clr = 1'b1;
            idx_d    = '0;
            fill_d   = '0;
            sum_d    = '0;
          end else if (op_i == OpCapture) begin
            last_d = cap_m;
            ovf_d  = '0;
            seen_d = 1'b1;
            if (seen_q) begin
              period_d = period_calc;
              state_d  = StMul;
            end
          end else begin
            state_d = StIdle;
          end
        end
      end
      StMul: begin
        div_start  = 1'b1;
        den_zero_d = (rpm_den == '0);
        state_d    = StDiv1;
      end
      StDiv1: begin
        if (!div_busy) begin
          rpm_d   = rpm_w;
          ring_wr = 1'b1;
          sum_d   = sum_q - SumW'(ring_q[idx_q]) + SumW'(rpm_w);
          idx_d   = (idx_q == IdxW'(WINDOW - 1)) ? '0 : idx_q + 1'b1;
          fill_d  = (fill_q < FillW'(WINDOW)) ? fill_q + 1'b1 : fill_q;
          div_start = 1'b1;
          div_num   = NumW'(sum_d);
          div_den   = DenW'(fill_d);
          state_d   = StDiv2;
        end
      end
      StDiv2: begin
        if (!div_busy && (!out_valid_q || !out_stall_i)) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // result register valid
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // shared bit-serial divider
  tprma_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tick_q      <= TickRateReset;
      ppr_q       <= PprReset;
      last_q      <= '0;
      seen_q      <= 1'b0;
      ovf_q       <= '0;
      idx_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      seen_q      <= seen_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgTickRate) tick_q <= cfg_data_i;
        if (cfg_index_i == CfgPulsesPerRev) ppr_q <= cfg_data_i[PprW-1:0];
      end
    end
  end

  // rpm sample ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) ring_q[i] <= '0;
    end else if (ring_clr) begin
      for (int i = 0; i < WINDOW; i++) ring_q[i] <= '0;
    end else if (ring_wr) begin
      ring_q[idx_q] <= rpm_w;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk_i) begin
    period_q   <= period_d;
    den_zero_q <= den_zero_d;
    rpm_q      <= rpm_d;
    if (out_load) begin
      out_period_q <= period_q;
      out_raw_q    <= rpm_q;
      out_filt_q   <= div_quot[RpmW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign period_ticks_o = out_period_q;
  assign raw_rpm_o      = out_raw_q;
  assign avg_rpm_o      = out_filt_q;

  // the divider is never left running while new beats are taken
  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !div_busy)
    else $error("divider busy while sequencer idle");

  // a result appears only at the end of the average division
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDiv2))
    else $error("result raised outside the average step");

  // fill count never exceeds the window
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WINDOW))
    else $error("fill count beyond window");

  // a delivered average and raw rpm never exceed the rpm ceiling
  a_filt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_filt_q <= RpmMax && out_raw_q <= RpmMax))
    else $error("rpm beyond ceiling");

endmodule
`default_nettype wire
